[rtl/plm_pkg.sv]
// ----------------------------------------------------------------------------
// plm_pkg: shared types and constants of the packet loss monitor
// Field widths, opcodes, event kinds, register indexes and a saturating adder.
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned MAX_BURST = 32;
  localparam int unsigned BIN_IDX_W = 6;
  localparam int unsigned HIST_AW   = $clog2(MAX_BURST);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] WINDOW_SIZE_RST    = CNT_W'(1000);
  localparam logic [SEQ_W-1:0] MAX_SEQ_RST        = '1;
  localparam logic [CNT_W-1:0] REORDER_WINDOW_RST = CNT_W'(10000);

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_READ   = 1'b1
  } plm_op_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_FWD  = 2'd1,
    EV_LATE = 2'd2,
    EV_WRAP = 2'd3
  } plm_event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE    = 2'd0,
    CFG_MAX_SEQ        = 2'd1,
    CFG_REORDER_WINDOW = 2'd2
  } plm_cfg_e;

  // Histogram access issued when a transaction is accepted.
  typedef struct packed {
    logic               rd;
    logic [HIST_AW-1:0] addr;
  } plm_hist_req_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

endpackage

[rtl/plm_hist.sv]
// ----------------------------------------------------------------------------
// plm_hist: burst length histogram
// Synchronous memory with per-entry valid bits, saturating read-modify-write
// and forwarding of the latest write into a read issued on the same edge.
// ----------------------------------------------------------------------------
module plm_hist
  import plm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  plm_hist_req_t    req_i,
  input  logic             wr_en_i,
  output logic [CNT_W-1:0] bin_val_o
);

  logic [CNT_W-1:0]   mem [MAX_BURST];
  logic [MAX_BURST-1:0] hvld_q;
  logic [CNT_W-1:0]   rdata_q;
  logic [HIST_AW-1:0] addr_q;
  logic               fwd_vld_q;
  logic [HIST_AW-1:0] fwd_addr_q;
  logic [CNT_W-1:0]   fwd_data_q;
  logic [CNT_W-1:0]   inc_val;
  logic               fwd_hit;

  assign fwd_hit   = fwd_vld_q && (fwd_addr_q == addr_q);
  assign bin_val_o = fwd_hit ? fwd_data_q : (hvld_q[addr_q] ? rdata_q : '0);
  assign inc_val   = sat_add(bin_val_o, CNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_q] <= inc_val;
    end
    if (req_i.rd) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvld_q     <= '0;
      addr_q     <= '0;
      fwd_vld_q  <= 1'b0;
      fwd_addr_q <= '0;
      fwd_data_q <= '0;
    end else begin
      if (req_i.rd) begin
        addr_q <= req_i.addr;
      end
      if (wr_en_i) begin
        hvld_q[addr_q] <= 1'b1;
        fwd_vld_q      <= 1'b1;
        fwd_addr_q     <= addr_q;
        fwd_data_q     <= inc_val;
      end
    end
  end

  // A written entry is marked valid.
  a_wr_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> hvld_q[$past(addr_q)])
    else $error("histogram write did not mark entry valid");

  // Right after a write to the held address, the readback is at least one.
  a_wr_readback : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && !req_i.rd) |=> (bin_val_o != '0))
    else $error("histogram readback lost the last increment");

endmodule

[rtl/packet_loss_monitor.sv]
// ----------------------------------------------------------------------------
// packet_loss_monitor: sequence number gap loss counter
// Classifies received sequence numbers, tallies losses per window and keeps
// a histogram of forward loss burst lengths.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one transaction per packet or histogram read. tuser is the
//   opcode (packet / read bin); tdata holds seq_num and bin_index.
//   m_axis returns exactly one result transaction per input transaction,
//   in order: tuser holds event_kind and window_done, tdata the counters.
//   cfg writes window_size, max_seq and reorder_window by index; the port is
//   always ready; the user writes it only while the block is idle (not enforced).
// Throughput and stages:
//   One transaction per cycle sustained while m_axis_tready is high. A result
//   passes the middle stage and then the output register: the scalar tallies
//   update and the histogram is read on the accept edge; when the middle stage
//   advances, the histogram write-back and the output register load on the
//   same edge.
// Reset:
//   Tallies clear, the first window restarts, registers take their defaults
//   and the histogram valid bits clear at once (no clearing pass).
// Stall:
//   When m_axis_tready is low a full output register holds; the middle stage,
//   if empty, still takes one more transaction before s_axis_tready drops.
// ----------------------------------------------------------------------------
module packet_loss_monitor
  import plm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,   // [31:0] seq_num, [37:32] bin_index
  input  logic                 s_axis_tuser,   // [0] opcode
  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [223:0]         m_axis_tdata,   // [31:0] gap_length, [63:32] first_missing,
                                               // [95:64] last_missing, [127:96] window_loss,
                                               // [159:128] window_number,
                                               // [191:160] late_count, [223:192] bin_count
  output logic [2:0]           m_axis_tuser,   // [1:0] event_kind, [2] window_done
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  typedef struct packed {
    logic             is_read;
    logic             bin_ok;
    plm_event_e       kind;
    logic [CNT_W-1:0] gap;
    logic [SEQ_W-1:0] first_miss;
    logic [SEQ_W-1:0] last_miss;
    logic             win_done;
    logic [CNT_W-1:0] win_loss;
    logic [CNT_W-1:0] win_num;
    logic [CNT_W-1:0] late_cnt;
    logic             inc;
  } plm_mid_t;

  // configuration registers
  logic [CNT_W-1:0] win_size_q;
  logic [SEQ_W-1:0] max_seq_q;
  logic [CNT_W-1:0] reorder_q;

  // tallies
  logic [SEQ_W-1:0] last_seq_q, last_seq_d;
  logic [CNT_W-1:0] pt_q, pt_d;
  logic [CNT_W-1:0] loss_q, loss_d;
  logic             first_q, first_d;
  logic [CNT_W-1:0] wc_q, wc_d;
  logic [CNT_W-1:0] late_q, late_d;

  // pipeline
  logic          v2_q, v3_q;
  plm_mid_t      mid_q, mid_d;
  logic [223:0]  tdata_q;
  logic [2:0]    tuser_q;
  logic          rdy3, s_fire, s2_fire;
  plm_hist_req_t hreq;
  logic [CNT_W-1:0] bin_val;

  // input fields
  plm_op_e              op;
  logic [SEQ_W-1:0]     cur;
  logic [BIN_IDX_W-1:0] bin_idx;

  assign op      = plm_op_e'(s_axis_tuser);
  assign cur     = s_axis_tdata[31:0];
  assign bin_idx = s_axis_tdata[37:32];

  assign rdy3          = !v3_q || m_axis_tready;
  assign s2_fire       = v2_q && rdy3;
  assign s_axis_tready = !v2_q || rdy3;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Classify a packet or decode a bin read; update the tallies in the accept cycle.
  always_comb begin
    logic             check, fwd, late, close;
    logic [CNT_W-1:0] gap_f, gap_w, head, pt1, excess;
    logic [SEQ_W-1:0] back;

    check  = 1'b0;
    fwd    = 1'b0;
    late   = 1'b0;
    close  = 1'b0;
    gap_f  = cur - last_seq_q - SEQ_W'(1);
    back   = last_seq_q - cur;
    head   = (max_seq_q > last_seq_q) ? (max_seq_q - last_seq_q) : '0;
    gap_w  = sat_add(head, cur);
    pt1    = sat_add(pt_q, CNT_W'(1));
    excess = '0;

    last_seq_d = last_seq_q;
    pt_d       = pt_q;
    loss_d     = loss_q;
    first_d    = first_q;
    wc_d       = wc_q;
    late_d     = late_q;

    mid_d            = '0;
    mid_d.is_read    = (op == OP_READ);
    mid_d.kind       = EV_NONE;
    hreq.rd          = 1'b0;
    hreq.addr        = '0;

    if (op == OP_READ) begin
      mid_d.bin_ok = (bin_idx != '0) && (bin_idx <= BIN_IDX_W'(MAX_BURST));
      hreq.rd      = s_fire && mid_d.bin_ok;
      hreq.addr    = HIST_AW'(bin_idx - BIN_IDX_W'(1));
    end else begin
      check = ({1'b0, cur} != ({1'b0, last_seq_q} + (SEQ_W+1)'(1))) && !first_q &&
              (last_seq_q != max_seq_q) && (cur != '0);
      fwd   = cur > last_seq_q;
      late  = back < reorder_q;

      pt_d       = pt1;
      last_seq_d = cur;

      if (check) begin
        if (fwd) begin
          loss_d           = sat_add(loss_q, gap_f);
          pt_d             = sat_add(pt1, gap_f);
          mid_d.kind       = EV_FWD;
          mid_d.gap        = gap_f;
          mid_d.first_miss = last_seq_q + SEQ_W'(1);
          mid_d.last_miss  = cur - SEQ_W'(1);
          mid_d.inc        = (gap_f <= CNT_W'(MAX_BURST));
          hreq.rd          = s_fire && mid_d.inc;
          hreq.addr        = HIST_AW'(gap_f - CNT_W'(1));
        end else if (late) begin
          late_d     = sat_add(late_q, CNT_W'(1));
          pt_d       = pt1 - CNT_W'(1);
          last_seq_d = last_seq_q;
          mid_d.kind = EV_LATE;
        end else begin
          loss_d           = sat_add(loss_q, gap_w);
          pt_d             = sat_add(pt1, gap_w);
          mid_d.kind       = EV_WRAP;
          mid_d.gap        = gap_w;
          mid_d.first_miss = last_seq_q + SEQ_W'(1);
          mid_d.last_miss  = cur - SEQ_W'(1);
        end
      end

      // Close the window and carry any excess over as packets and losses.
      close = pt_d >= win_size_q;
      if (close) begin
        excess         = pt_d - win_size_q;
        first_d        = 1'b0;
        wc_d           = wc_q + CNT_W'(1);
        mid_d.win_done = 1'b1;
        mid_d.win_loss = (loss_d > excess) ? (loss_d - excess) : '0;
        mid_d.win_num  = wc_d;
        pt_d           = excess;
        loss_d         = excess;
      end
    end
    mid_d.late_cnt = late_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WINDOW_SIZE_RST;
      max_seq_q  <= MAX_SEQ_RST;
      reorder_q  <= REORDER_WINDOW_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_SIZE:    win_size_q <= cfg_data_i;
        CFG_MAX_SEQ:        max_seq_q  <= cfg_data_i;
        CFG_REORDER_WINDOW: reorder_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the tallies on each accepted packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '0;
      pt_q       <= '0;
      loss_q     <= '0;
      first_q    <= 1'b1;
      wc_q       <= '0;
      late_q     <= '0;
    end else if (s_fire) begin
      last_seq_q <= last_seq_d;
      pt_q       <= pt_d;
      loss_q     <= loss_d;
      first_q    <= first_d;
      wc_q       <= wc_d;
      late_q     <= late_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s_fire) begin
        v2_q <= 1'b1;
      end else if (s2_fire) begin
        v2_q <= 1'b0;
      end
      if (s2_fire) begin
        v3_q <= 1'b1;
      end else if (m_axis_tready) begin
        v3_q <= 1'b0;
      end
    end
  end

  // Payload registers: middle stage and output stage.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      mid_q <= mid_d;
    end
    if (s2_fire) begin
      tdata_q <= {(mid_q.is_read && mid_q.bin_ok) ? bin_val : CNT_W'(0),
                  mid_q.late_cnt, mid_q.win_num, mid_q.win_loss,
                  mid_q.last_miss, mid_q.first_miss, mid_q.gap};
      tuser_q <= {mid_q.win_done, mid_q.kind};
    end
  end

  plm_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hreq),
    .wr_en_i   (s2_fire && mid_q.inc),
    .bin_val_o (bin_val)
  );

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  // Both stages full and the receiver stalled: the input must be held off.
  a_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && v3_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted with full pipeline");

  // A closing window advances the window count by one.
  a_window_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (op == OP_PACKET) && mid_d.win_done) |=> (wc_q == $past(wc_q) + CNT_W'(1)))
    else $error("window count did not advance");

  // Once the first window has closed it never reopens.
  a_first_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |=> !first_q)
    else $error("first window flag set again");

  // Every middle-stage transaction reaches the output register.
  a_mid_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |=> m_axis_tvalid)
    else $error("result lost between stages");

endmodule

[test/tb_packet_loss_monitor.sv]
// ----------------------------------------------------------------------------
// tb_packet_loss_monitor: self-checking bench for the packet loss monitor
// Drives a directed table and then random sequence-number runs under several
// register settings; results are checked against bench predictions or typed rows.
// ----------------------------------------------------------------------------
module tb_packet_loss_monitor
  import plm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS_PER_PHASE = 166;
  localparam int unsigned RANDOM_PHASE    = 3;
  localparam int unsigned DRAIN_LIMIT     = 2000;

  // One expected result transaction, field by field.
  typedef struct {
    plm_event_e kind;
    bit [31:0]  gap_len;
    bit [31:0]  first_miss;
    bit [31:0]  last_miss;
    bit         closed;
    bit [31:0]  closed_loss;
    bit [31:0]  closed_num;
    bit [31:0]  late_cnt;
    bit [31:0]  bin_cnt;
  } loss_report_t;

  // One row of the directed table: a register write or a stimulus transaction.
  // Rows with typed set carry a hand-written expectation.
  typedef struct {
    bit           is_write;
    plm_cfg_e     reg_idx;
    bit [31:0]    value;
    plm_op_e      op;
    bit [31:0]    seq;
    bit [5:0]     bin;
    bit           typed;
    loss_report_t want;
  } script_row_t;

  typedef struct {
    bit [31:0] win;
    bit [31:0] max;
    bit [31:0] reorder;
    bit        idle;
  } setting_t;

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata  = '0;   // [31:0] seq_num, [37:32] bin_index
  logic         s_axis_tuser  = 1'b0; // [0] opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [223:0] m_axis_tdata;         // gap_length, first_missing, last_missing,
                                      // window_loss, window_number, late_count,
                                      // bin_count, 32 bits each from bit 0 up
  logic [2:0]   m_axis_tuser;         // [1:0] event_kind, [2] window_done
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  plm_cfg_e     cfg_index_i = CFG_WINDOW_SIZE;
  logic [31:0]  cfg_data_i  = '0;

  // Predictor state: registers and tallies as the block should hold them.
  bit [31:0] win_size     = WINDOW_SIZE_RST;
  bit [31:0] seq_max      = MAX_SEQ_RST;
  bit [31:0] reorder_span = REORDER_WINDOW_RST;
  bit [31:0] seq_prev     = '0;
  bit [31:0] pkt_tally    = '0;
  bit [31:0] loss_tally   = '0;
  bit        in_first_window = 1'b1;
  bit [31:0] win_count    = '0;
  bit [31:0] late_tally   = '0;
  bit [31:0] burst_hist [1:MAX_BURST];

  loss_report_t expected_reports [$];
  script_row_t  script [$];
  setting_t     plan [8];

  int unsigned failures  = 0;
  int unsigned packets   = 0;
  int unsigned reads     = 0;
  int unsigned closes    = 0;
  int unsigned kind_seen [4];
  bit          idle_en   = 1'b1;
  int          sink_hold = 0;

  packet_loss_monitor i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Add and clamp at the top of the 32-bit range.
  function automatic bit [31:0] add_clamped(input bit [31:0] a, input bit [31:0] b);
    bit [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  // Classify one arrived packet, advance the tallies and return its report.
  function automatic loss_report_t track_packet(input bit [31:0] cur);
    loss_report_t r;
    bit [31:0]    gap;
    bit [31:0]    head;
    bit [31:0]    excess;
    r = '{kind: EV_NONE, default: '0};
    pkt_tally = add_clamped(pkt_tally, 32'd1);
    // Compare against prev+1 in 33 bits so an all-ones previous never matches.
    if ({1'b0, cur} != {1'b0, seq_prev} + 33'd1 && !in_first_window &&
        seq_prev != seq_max && cur != '0) begin
      if (cur > seq_prev) begin
        // Forward gap: a loss burst, histogram only for short bursts.
        gap = cur - seq_prev - 32'd1;
        if (gap <= MAX_BURST) burst_hist[gap] = add_clamped(burst_hist[gap], 32'd1);
        loss_tally   = add_clamped(loss_tally, gap);
        pkt_tally    = add_clamped(pkt_tally, gap);
        r.kind       = EV_FWD;
        r.gap_len    = gap;
        r.first_miss = seq_prev + 32'd1;
        r.last_miss  = cur - 32'd1;
        seq_prev     = cur;
      end else if (seq_prev - cur < reorder_span) begin
        // Late or duplicate: take the packet back out of the tally, keep prev.
        late_tally = add_clamped(late_tally, 32'd1);
        if (pkt_tally != '0) pkt_tally--;
        r.kind = EV_LATE;
      end else begin
        // Loss across the wrap; a previous above max_seq has no head part.
        head         = (seq_max > seq_prev) ? seq_max - seq_prev : '0;
        gap          = add_clamped(head, cur);
        loss_tally   = add_clamped(loss_tally, gap);
        pkt_tally    = add_clamped(pkt_tally, gap);
        r.kind       = EV_WRAP;
        r.gap_len    = gap;
        r.first_miss = seq_prev + 32'd1;
        r.last_miss  = cur - 32'd1;
        seq_prev     = cur;
      end
    end else begin
      seq_prev = cur;
    end
    // Close the window; carry the excess into the next one.
    if (pkt_tally >= win_size) begin
      excess          = pkt_tally - win_size;
      in_first_window = 1'b0;
      if (excess != '0) loss_tally = (loss_tally > excess) ? loss_tally - excess : '0;
      win_count       = win_count + 32'd1;
      r.closed        = 1'b1;
      r.closed_loss   = loss_tally;
      r.closed_num    = win_count;
      pkt_tally       = excess;
      loss_tally      = excess;
    end
    r.late_cnt = late_tally;
    return r;
  endfunction

  function automatic loss_report_t read_bin(input bit [5:0] bin);
    loss_report_t r;
    r = '{kind: EV_NONE, default: '0};
    if (bin >= 1 && bin <= MAX_BURST) r.bin_cnt = burst_hist[bin];
    r.late_cnt = late_tally;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic loss_report_t make_report(
      input plm_event_e kind, input bit [31:0] gap_len, input bit [31:0] first_miss,
      input bit [31:0] last_miss, input bit closed, input bit [31:0] closed_loss,
      input bit [31:0] closed_num, input bit [31:0] late_cnt, input bit [31:0] bin_cnt);
    return '{kind, gap_len, first_miss, last_miss, closed, closed_loss, closed_num,
             late_cnt, bin_cnt};
  endfunction

  function automatic script_row_t cfg_row(input plm_cfg_e idx, input bit [31:0] value);
    script_row_t r;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.value    = value;
    r.typed    = 1'b0;
    return r;
  endfunction

  function automatic script_row_t fixed_row(input plm_op_e op, input bit [31:0] seq,
                                            input bit [5:0] bin, input loss_report_t want);
    script_row_t r;
    r.is_write = 1'b0;
    r.op       = op;
    r.seq      = seq;
    r.bin      = bin;
    r.typed    = 1'b1;
    r.want     = want;
    return r;
  endfunction

  function automatic script_row_t pkt_row(input bit [31:0] seq);
    script_row_t r;
    r.is_write = 1'b0;
    r.op       = OP_PACKET;
    r.seq      = seq;
    r.bin      = 6'h2A;
    r.typed    = 1'b0;
    return r;
  endfunction

  function automatic script_row_t read_row(input bit [5:0] bin);
    script_row_t r;
    r.is_write = 1'b0;
    r.op       = OP_READ;
    r.seq      = 32'hA5A5_5A5A;
    r.bin      = bin;
    r.typed    = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one stimulus transaction, optionally after an idle burst, and log
  // its expectation at the accepting edge. Returns at the next falling edge.
  task automatic send_item(input plm_op_e op, input bit [31:0] seq, input bit [5:0] bin,
                           input bit typed, input loss_report_t want);
    loss_report_t pred;
    cfg_valid_i <= 1'b0;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, bin, seq};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_READ) begin
      pred = read_bin(bin);
      reads++;
    end else begin
      pred = track_packet(seq);
      packets++;
      kind_seen[pred.kind]++;
      if (pred.closed) closes++;
    end
    expected_reports.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  // Write one register; valid stays up so back-to-back writes need no dip.
  task automatic write_reg(input plm_cfg_e idx, input bit [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_WINDOW_SIZE:    win_size     = value;
      CFG_MAX_SEQ:        seq_max      = value;
      CFG_REORDER_WINDOW: reorder_span = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Hold off the stimulus until every outstanding result has come back or the
  // drain limit runs out, then let the pipeline settle.
  task automatic wait_idle();
    int unsigned spins;
    spins = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk_i);
      spins++;
    end
    if (expected_reports.size() != 0) begin
      $error("%0d expected results never arrived", expected_reports.size());
      failures += expected_reports.size();
      expected_reports.delete();
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Result side: stall in random bursts while idling is on.
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    loss_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        $error("result transaction with nothing outstanding");
        failures++;
      end else begin
        want = expected_reports.pop_front();
        check_field("event_kind",    32'(want.kind),   32'(m_axis_tuser[1:0]));
        check_field("window_done",   32'(want.closed), 32'(m_axis_tuser[2]));
        check_field("gap_length",    want.gap_len,     m_axis_tdata[31:0]);
        check_field("first_missing", want.first_miss,  m_axis_tdata[63:32]);
        check_field("last_missing",  want.last_miss,   m_axis_tdata[95:64]);
        check_field("window_loss",   want.closed_loss, m_axis_tdata[127:96]);
        check_field("window_number", want.closed_num,  m_axis_tdata[159:128]);
        check_field("late_count",    want.late_cnt,    m_axis_tdata[191:160]);
        check_field("bin_count",     want.bin_cnt,     m_axis_tdata[223:192]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned pick;
    bit [32:0]   ahead;
    plm_op_e     op;
    bit [31:0]   seq;
    bit [5:0]    bin;

    foreach (burst_hist[b]) burst_hist[b] = '0;

    // Directed table. Reset defaults hold at first: window 1000, no wrap below
    // all-ones, reorder span 10000.
    script = '{
      // Reads right after reset see a cleared histogram; out-of-range bins read 0.
      fixed_row(OP_READ, 32'h0, 6'd1,  make_report(EV_NONE, 0, 0, 0, 0, 0, 0, 0, 0)),
      fixed_row(OP_READ, '1,    6'd0,  make_report(EV_NONE, 0, 0, 0, 0, 0, 0, 0, 0)),
      fixed_row(OP_READ, 32'h0, 6'd63, make_report(EV_NONE, 0, 0, 0, 0, 0, 0, 0, 0)),
      // First window: everything is taken as in order, whatever the jump.
      fixed_row(OP_PACKET, '1,    6'd63, make_report(EV_NONE, 0, 0, 0, 0, 0, 0, 0, 0)),
      fixed_row(OP_PACKET, 32'h0, 6'd0,  make_report(EV_NONE, 0, 0, 0, 0, 0, 0, 0, 0)),
      cfg_row(CFG_WINDOW_SIZE, 32'd3),
      // Third packet closes the first window with no loss.
      fixed_row(OP_PACKET, 32'd7, 6'd0, make_report(EV_NONE, 0, 0, 0, 1, 0, 1, 0, 0)),
      pkt_row(32'd8),             // in order
      pkt_row(32'd12),            // forward gap of 3, excess carried into next window
      pkt_row(32'd10),            // late
      pkt_row(32'd12),            // duplicate
      pkt_row(32'd0),             // zero is always in order
      pkt_row(32'd33),            // burst of 32, the top histogram bin
      pkt_row(32'd67),            // burst of 33, beyond the histogram
      pkt_row(32'd69),            // burst of 1
      read_row(6'd32),
      read_row(6'd1),
      fixed_row(OP_READ, 32'h0, 6'd33, make_report(EV_NONE, 0, 0, 0, 0, 0, 0, 2, 0)),
      cfg_row(CFG_MAX_SEQ, 32'd100),
      cfg_row(CFG_REORDER_WINDOW, 32'd5),
      pkt_row(32'd64),            // backward by exactly the span: wrap loss
      pkt_row(32'd100),           // forward to max_seq
      pkt_row(32'd3),             // previous at max_seq: in order
      pkt_row(32'd1),             // late inside the span
      pkt_row('1),                // forward to all ones, above max_seq
      pkt_row(32'd2),             // wrap with previous above max_seq: no head part
      cfg_row(CFG_REORDER_WINDOW, 32'd0),
      pkt_row(32'd2),             // duplicate with zero span counts as wrap loss
      cfg_row(CFG_WINDOW_SIZE, 32'd0),
      pkt_row(32'd3),             // zero window: every packet closes one
      pkt_row(32'd9)
    };

    // Register settings for the random phases; the random one is drawn below.
    plan = '{
      '{32'd4,         32'd200,       32'd10000,     1'b0},
      '{32'd1,         32'd1000,      32'd3,         1'b1},
      '{32'd0,         32'd1,         32'd1,         1'b1},
      '{32'd16,        32'd4096,      32'd7,         1'b1},
      '{32'd37,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
      '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd50,        1'b1},
      '{32'd0,         32'hFFFF_FFFF, 32'd0,         1'b1},
      '{32'd8,         32'hFFFF_FFFF, 32'd10000,     1'b0}
    };
    plan[RANDOM_PHASE].win     = $urandom_range(1, 64);
    plan[RANDOM_PHASE].max     = $urandom_range(16, 4096);
    plan[RANDOM_PHASE].reorder = $urandom_range(0, 20);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the table; drain before any register write that follows traffic.
    foreach (script[i]) begin
      if (script[i].is_write) begin
        if (i > 0 && !script[i-1].is_write) wait_idle();
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        send_item(script[i].op, script[i].seq, script[i].bin, script[i].typed,
                  script[i].want);
      end
    end

    // Random phases: mostly well-formed runs around the last accepted number,
    // with gaps, late and duplicate packets, wraps, noise and histogram reads.
    foreach (plan[p]) begin
      wait_idle();
      idle_en = plan[p].idle;
      write_reg(CFG_WINDOW_SIZE,    plan[p].win);
      write_reg(CFG_MAX_SEQ,        plan[p].max);
      write_reg(CFG_REORDER_WINDOW, plan[p].reorder);
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        op   = OP_PACKET;
        bin  = 6'($urandom_range(0, 63));
        seq  = $urandom;
        if (pick < 10) begin
          op = OP_READ;
          if (pick < 7) bin = 6'($urandom_range(1, MAX_BURST));
        end else if (pick < 14) begin
          seq = (seq_max == '1) ? $urandom : $urandom_range(0, seq_max);
        end else if (pick < 30) begin
          seq = seq_prev - 32'($urandom_range(0, 4));
        end else if (pick < 34) begin
          seq = 32'($urandom_range(0, 2));
        end else begin
          // Step forward and fold back past max_seq like a real sender.
          ahead = {1'b0, seq_prev} +
                  33'((pick < 70) ? 1 : (pick < 92) ? $urandom_range(2, 6)
                                                    : $urandom_range(7, 40));
          if (ahead > {1'b0, seq_max}) ahead = ahead - {1'b0, seq_max} - 33'd1;
          seq = ahead[31:0];
        end
        send_item(op, seq, bin, 1'b0, read_bin(6'd0));
      end
    end

    wait_idle();
    $display("Run covered %0d packets and %0d bin reads over %0d register settings.",
             packets, reads, $size(plan) + 1);
    $display("Events in order/forward/late/wrap: %0d/%0d/%0d/%0d, windows closed: %0d",
             kind_seen[EV_NONE], kind_seen[EV_FWD], kind_seen[EV_LATE],
             kind_seen[EV_WRAP], closes);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $error("timeout with %0d results outstanding", expected_reports.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
